### rtl/core/mlrs_pkg.sv
// ----------------------------------------------------------------------------
// mlrs_pkg
// Shared types and constants of the moving linear regression smoother.
// ----------------------------------------------------------------------------
package mlrs_pkg;

  localparam int HW_W   = 4;
  localparam int IDX_W  = 5;
  localparam int SEEN_W = 6;
  localparam int SMP_W  = 16;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHIFT,
    OP_ACC,
    OP_MUL,
    OP_SUM,
    OP_DIVB,
    OP_TAKEB,
    OP_DIVX,
    OP_TAKEX,
    OP_LINE,
    OP_EMIT,
    OP_TAKEE,
    OP_ZERO,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [HW_W-1:0]  h;
    logic [IDX_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

endpackage

### rtl/core/mlrs_div.sv
// ----------------------------------------------------------------------------
// mlrs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlrs_div #(
  parameter int NW = 44,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

### rtl/core/mlrs_dp.sv
// ----------------------------------------------------------------------------
// mlrs_dp
// Datapath: sample window, overlap sums, window moments, incremental line
// evaluation and the shared divider.
// ----------------------------------------------------------------------------
module mlrs_dp #(
  parameter int MAX_HALF_WINDOW = 8,
  parameter int FRAC_BITS       = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mlrs_pkg::cmd_t                     cmd,
  output mlrs_pkg::stat_t                    stat,
  input  logic signed [mlrs_pkg::SMP_W-1:0]  in_sample,
  output logic signed [mlrs_pkg::SMP_W-1:0]  out_smoothed_sample
);
  import mlrs_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int HH_W  = 2 * HW_W;
  localparam int DW    = AW + HH_W;
  localparam int SW    = SMP_W + AW;
  localparam int TW    = SMP_W + HH_W + 1;
  localparam int NW    = SMP_W + AW + 3 * HW_W + 3 + FRAC_BITS;

  logic signed [SMP_W-1:0] win_r  [DEPTH];
  logic signed [NW-1:0]    sums_r [DEPTH];

  logic signed [SW-1:0]        s_r;
  logic signed [TW-1:0]        t_r;
  logic signed [SW+HH_W:0]     sh_r;
  logic signed [TW+1:0]        t3_r;
  logic signed [NW-1:0]        num_r;
  logic signed [NW-1:0]        b_r;
  logic signed [NW-1:0]        x_r;
  logic signed [NW-1:0]        q_r;
  logic signed [DW:0]          r_r;
  logic signed [NW-1:0]        qb_r;
  logic signed [DW:0]          rb_r;
  logic                        bneg_r;
  logic                        xneg_r;
  logic                        eneg_r;
  logic signed [SMP_W-1:0]     out_r;

  logic [AW-1:0]               ia;
  logic signed [SMP_W-1:0]     sel_v;
  logic signed [5:0]           ofs;
  logic signed [SMP_W+5:0]     prod;
  logic [HH_W-1:0]             hh;
  logic [DW-1:0]               d_val;
  logic [DW-1:0]               hd;
  logic signed [TW+1:0]        t3;
  logic signed [TW+HW_W+2:0]   th;
  logic signed [NW-1:0]        num0;
  logic signed [NW-1:0]        esel;
  logic [NW-1:0]               emag;
  logic [NW-1:0]               half;
  logic [NW-1:0]               m2;
  logic                        div_start;
  logic [NW-1:0]               div_num;
  logic [DW-1:0]               div_den;
  logic                        div_busy;
  logic [NW-1:0]               quot;
  logic [DW-1:0]               rem;
  logic signed [NW-1:0]        fq;
  logic signed [DW:0]          fr;
  logic                        fneg;
  logic signed [NW-1:0]        line_v;
  logic signed [DW:0]          rn;
  logic signed [NW-1:0]        qn;

  assign ia    = cmd.idx[AW-1:0];
  assign sel_v = win_r[ia];
  assign ofs   = $signed({2'b00, cmd.h}) - $signed({1'b0, cmd.idx});
  assign prod  = ofs * sel_v;
  assign hh    = HH_W'(cmd.h) * (HH_W'(cmd.h) + 1'b1);
  assign d_val = DW'({cmd.h, 1'b1}) * DW'(hh);
  assign hd    = d_val >> 1;
  assign t3    = (TW+2)'(t_r) + ((TW+2)'(t_r) <<< 1);
  assign th    = t3_r * $signed({1'b0, cmd.h});
  assign num0  = (NW'(sh_r) + NW'(th)) <<< FRAC_BITS;

  assign esel = sums_r[ia];
  assign emag = esel[NW-1] ? NW'(-esel) : NW'(esel);
  assign half = (NW'(cmd.cnt) << FRAC_BITS) >> 1;
  assign m2   = (emag + half) >> FRAC_BITS;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = d_val;
    case (cmd.op)
      OP_DIVB: begin
        div_start = 1'b1;
        div_num   = b_r[NW-1] ? NW'(-b_r) : NW'(b_r);
      end
      OP_DIVX: begin
        div_start = 1'b1;
        div_num   = x_r[NW-1] ? NW'(-x_r) : NW'(x_r);
      end
      OP_EMIT: begin
        div_start = 1'b1;
        div_num   = m2;
        div_den   = DW'(cmd.cnt);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  mlrs_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot),
    .rem   (rem)
  );

  assign stat.div_busy = div_busy;

  // Floor division of a signed value from the magnitude quotient.
  always_comb begin
    fneg = (cmd.op == OP_TAKEB) ? bneg_r : xneg_r;
    if (fneg && (rem != '0)) begin
      fq = -$signed(quot) - 1'b1;
      fr = $signed({1'b0, d_val}) - $signed({1'b0, rem});
    end else if (fneg) begin
      fq = -$signed(quot);
      fr = '0;
    end else begin
      fq = $signed(quot);
      fr = $signed({1'b0, rem});
    end
  end

  always_comb begin
    line_v = num_r[NW-1] ? ((r_r == '0) ? q_r - 1'b1 : q_r) : q_r;
    rn     = r_r - rb_r;
    qn     = q_r - qb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < DEPTH; a++) begin
        sums_r[a] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_SHIFT: begin
          for (int a = DEPTH - 1; a > 0; a--) begin
            sums_r[a] <= sums_r[a-1];
          end
          sums_r[0] <= '0;
        end
        OP_LINE:  sums_r[ia] <= sums_r[ia] + line_v;
        OP_EMIT:  sums_r[ia] <= '0;
        OP_CLEAR: begin
          for (int a = 0; a < DEPTH; a++) begin
            sums_r[a] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SHIFT: begin
        for (int a = DEPTH - 1; a > 0; a--) begin
          win_r[a] <= win_r[a-1];
        end
        win_r[0] <= in_sample;
        s_r      <= '0;
        t_r      <= '0;
      end
      OP_ACC: begin
        s_r <= s_r + SW'(sel_v);
        t_r <= t_r + TW'(prod);
      end
      OP_MUL: begin
        sh_r <= s_r * $signed({1'b0, hh});
        t3_r <= t3;
      end
      OP_SUM: begin
        num_r <= num0;
        b_r   <= NW'(t3_r) <<< FRAC_BITS;
      end
      OP_DIVB: begin
        bneg_r <= b_r[NW-1];
        x_r    <= num_r + $signed(NW'(hd));
      end
      OP_TAKEB: begin
        qb_r <= fq;
        rb_r <= fr;
      end
      OP_DIVX: xneg_r <= x_r[NW-1];
      OP_TAKEX: begin
        q_r <= fq;
        r_r <= fr;
      end
      OP_LINE: begin
        num_r <= num_r - b_r;
        if (rn[DW]) begin
          r_r <= rn + $signed({1'b0, d_val});
          q_r <= qn - 1'b1;
        end else begin
          r_r <= rn;
          q_r <= qn;
        end
      end
      OP_EMIT: eneg_r <= esel[NW-1];
      OP_TAKEE: begin
        if (eneg_r) begin
          out_r <= (quot >= NW'(32768)) ? 16'sh8000 : -$signed(quot[SMP_W-1:0]);
        end else begin
          out_r <= (quot >= NW'(32768)) ? 16'sh7fff : $signed(quot[SMP_W-1:0]);
        end
      end
      OP_ZERO: out_r <= '0;
      default: begin
      end
    endcase
  end

  assign out_smoothed_sample = out_r;

endmodule

### rtl/core/mlrs_ctrl.sv
// ----------------------------------------------------------------------------
// mlrs_ctrl
// Controller: sequences one input beat through moments, line evaluation,
// emission and flush, and holds the half window register.
// ----------------------------------------------------------------------------
module mlrs_ctrl #(
  parameter int MAX_HALF_WINDOW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_last_in,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_last_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mlrs_pkg::HW_W-1:0]   cfg_half_window,
  output mlrs_pkg::cmd_t              cmd,
  input  mlrs_pkg::stat_t             stat
);
  import mlrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_MUL, S_SUM, S_DIVB, S_WAITB, S_DIVX, S_WAITX,
    S_LINE, S_EMIT, S_WAITE, S_ZERO, S_OUT, S_CLEAR
  } state_t;

  typedef enum logic [1:0] {PH_MAIN, PH_FLUSH, PH_SHORT} phase_t;

  localparam logic [HW_W-1:0]   HMAX     = HW_W'(MAX_HALF_WINDOW);
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  state_t            state_r;
  phase_t            phase_r;
  logic [HW_W-1:0]   hw_r;
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] len_r;
  logic              last_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  fa_r;
  logic              out_valid_r;
  logic              out_last_r;

  logic [HW_W-1:0]   h_eff;
  logic [IDX_W-1:0]  two_h;
  logic [IDX_W-1:0]  w;
  logic [SEEN_W-1:0] len_nxt;
  logic              full;
  logic [SEEN_W-1:0] p;
  logic [IDX_W-1:0]  main_cnt;
  logic [SEEN_W-1:0] room;
  logic [IDX_W-1:0]  fc_first;
  logic [IDX_W-1:0]  fc_next;
  logic [IDX_W-1:0]  fa_dec;

  always_comb begin
    if (hw_r == '0) begin
      h_eff = HW_W'(1);
    end else if (hw_r > HMAX) begin
      h_eff = HMAX;
    end else begin
      h_eff = hw_r;
    end
    two_h    = {h_eff, 1'b0};
    w        = two_h + 1'b1;
    len_nxt  = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
    full     = len_nxt >= SEEN_W'(w);
    p        = len_r - SEEN_W'(w);
    main_cnt = (p < SEEN_W'(two_h)) ? IDX_W'(p + 1'b1) : w;
    room     = len_r - SEEN_W'(two_h);
    fa_dec   = fa_r - 1'b1;
    fc_first = (SEEN_W'(two_h) < room) ? two_h : IDX_W'(room);
    fc_next  = (SEEN_W'(fa_dec) < room) ? fa_dec : IDX_W'(room);
  end

  always_comb begin
    cmd.idx = idx_r;
    cmd.h   = h_eff;
    cmd.cnt = cnt_r;
    case (state_r)
      S_IDLE:  cmd.op = in_valid ? OP_SHIFT : OP_NONE;
      S_ACC:   cmd.op = OP_ACC;
      S_MUL:   cmd.op = OP_MUL;
      S_SUM:   cmd.op = OP_SUM;
      S_DIVB:  cmd.op = OP_DIVB;
      S_WAITB: cmd.op = stat.div_busy ? OP_NONE : OP_TAKEB;
      S_DIVX:  cmd.op = OP_DIVX;
      S_WAITX: cmd.op = stat.div_busy ? OP_NONE : OP_TAKEX;
      S_LINE:  cmd.op = OP_LINE;
      S_EMIT:  cmd.op = OP_EMIT;
      S_WAITE: cmd.op = stat.div_busy ? OP_NONE : OP_TAKEE;
      S_ZERO:  cmd.op = OP_ZERO;
      S_CLEAR: cmd.op = OP_CLEAR;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_MAIN;
      hw_r        <= HW_W'(4);
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        hw_r <= cfg_half_window;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            last_r <= in_last_in;
            len_r  <= len_nxt;
            seen_r <= len_nxt;
            if (full) begin
              phase_r <= PH_MAIN;
              idx_r   <= '0;
              state_r <= S_ACC;
            end else if (in_last_in) begin
              phase_r <= PH_SHORT;
              cnt_r   <= IDX_W'(len_nxt);
              state_r <= S_ZERO;
            end
          end
        end
        S_ACC: begin
          if (idx_r == two_h) begin
            state_r <= S_MUL;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MUL:  state_r <= S_SUM;
        S_SUM:  state_r <= S_DIVB;
        S_DIVB: state_r <= S_WAITB;
        S_WAITB: begin
          if (!stat.div_busy) begin
            state_r <= S_DIVX;
          end
        end
        S_DIVX: state_r <= S_WAITX;
        S_WAITX: begin
          if (!stat.div_busy) begin
            idx_r   <= '0;
            state_r <= S_LINE;
          end
        end
        S_LINE: begin
          if (idx_r == two_h) begin
            cnt_r   <= main_cnt;
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EMIT: state_r <= S_WAITE;
        S_WAITE: begin
          if (!stat.div_busy) begin
            out_valid_r <= 1'b1;
            out_last_r  <= (phase_r == PH_FLUSH) && (fa_r == IDX_W'(1));
            state_r     <= S_OUT;
          end
        end
        S_ZERO: begin
          out_valid_r <= 1'b1;
          out_last_r  <= cnt_r == IDX_W'(1);
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            out_last_r  <= 1'b0;
            case (phase_r)
              PH_MAIN: begin
                if (last_r) begin
                  phase_r <= PH_FLUSH;
                  fa_r    <= two_h;
                  idx_r   <= two_h - 1'b1;
                  cnt_r   <= fc_first;
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_IDLE;
                end
              end
              PH_FLUSH: begin
                if (fa_r == IDX_W'(1)) begin
                  state_r <= S_CLEAR;
                end else begin
                  fa_r    <= fa_dec;
                  idx_r   <= fa_dec - 1'b1;
                  cnt_r   <= fc_next;
                  state_r <= S_EMIT;
                end
              end
              PH_SHORT: begin
                if (cnt_r == IDX_W'(1)) begin
                  state_r <= S_CLEAR;
                end else begin
                  cnt_r   <= cnt_r - 1'b1;
                  state_r <= S_ZERO;
                end
              end
              default: state_r <= S_CLEAR;
            endcase
          end
        end
        S_CLEAR: begin
          seen_r  <= '0;
          phase_r <= PH_MAIN;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall     = state_r != S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_last_out = out_last_r;
  assign cfg_ready    = 1'b1;

endmodule

### rtl/core/moving_linear_regression_smoother.sv
// Moving linear regression smoother. Each input beat carries one signed
// sample; once 2h+1 samples of a record are present, every beat fits a
// least-squares line to the newest window, adds its values into per-position
// overlap sums and returns the oldest finished position as a rounded,
// saturated average. A beat flagged last then flushes the 2h remaining
// positions, and a record shorter than a window returns one zero per sample.
// One beat is handled at a time. A beat with a full window uses the
// one-bit-per-cycle divider twice for the line fit and once per result,
// flushed results included. A beat without a full window is only stored,
// unless it ends a short record and so starts the zero results. The half
// window register may be written only while the block is idle.
// ----------------------------------------------------------------------------
// moving_linear_regression_smoother
// Top level: controller, datapath and port wiring.
// ----------------------------------------------------------------------------
module moving_linear_regression_smoother #(
  parameter int MAX_HALF_WINDOW = 8,
  parameter int FRAC_BITS       = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mlrs_pkg::SMP_W-1:0]  in_sample,
  input  logic                               in_last_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mlrs_pkg::SMP_W-1:0]  out_smoothed_sample,
  output logic                               out_last_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mlrs_pkg::HW_W-1:0]          cfg_half_window
);
  import mlrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mlrs_ctrl #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_in      (in_last_in),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_last_out    (out_last_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_half_window (cfg_half_window),
    .cmd             (cmd),
    .stat            (stat)
  );

  mlrs_dp #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_sample           (in_sample),
    .out_smoothed_sample (out_smoothed_sample)
  );

endmodule

### rtl/core/mlrs_checker.sv
// ----------------------------------------------------------------------------
// mlrs_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module mlrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [mlrs_pkg::SMP_W-1:0] out_smoothed_sample,
  input logic                              out_last_out
);

  // No new beat is taken while a result is pending.
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smoothed_sample)
      && $stable(out_last_out))
    else $error("stalled result changed");

  // Every result needs fresh work, so a taken result is never followed at once by another.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("back-to-back results");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !out_last_out)
    else $error("result valid after reset");

endmodule

bind moving_linear_regression_smoother mlrs_checker u_mlrs_checker (.*);
